>>> rtl/i2crbm_pkg.sv
// ----------------------------------------------------------------------------
// i2crbm_pkg
// shared types and constants of the i2c register burst master
// ----------------------------------------------------------------------------
package i2crbm_pkg;

    // bus phase codes
    typedef enum logic [4:0] {
        PH_IDLE  = 5'd0,
        PH_S_A   = 5'd1,
        PH_S_B   = 5'd2,
        PH_S_C   = 5'd3,
        PH_TX_LO = 5'd4,
        PH_TX_HI = 5'd5,
        PH_TA_HI = 5'd6,
        PH_TA_LO = 5'd7,
        PH_RS    = 5'd8,
        PH_RX_LO = 5'd9,
        PH_RX_HI = 5'd10,
        PH_K_LO  = 5'd11,
        PH_K_HI  = 5'd12,
        PH_P_A   = 5'd13,
        PH_P_B   = 5'd14,
        PH_P_C   = 5'd15
    } t_phase;

    // request kinds carried with each tick
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_BURST = 2'd3
    } t_mode;

    // configuration register indexes
    localparam logic [7:0] CFG_DEV_ADDR    = 8'd0;
    localparam logic [7:0] CFG_BURST_REG   = 8'd1;
    localparam logic [7:0] CFG_BURST_LEN   = 8'd2;
    localparam logic [7:0] CFG_PHASE_TICKS = 8'd3;

    // configuration reset values
    localparam logic [6:0] DEV_ADDR_RST    = 7'h53;
    localparam logic [7:0] BURST_REG_RST   = 8'h32;
    localparam logic [4:0] BURST_LEN_RST   = 5'd6;
    localparam logic [7:0] PHASE_TICKS_RST = 8'd5;

    typedef struct packed {
        logic [6:0] dev_addr;
        logic [7:0] burst_reg;
        logic [4:0] burst_len;
        logic [7:0] phase_ticks;
    } t_cfg;

    typedef struct packed {
        t_mode      kind;
        logic [7:0] reg_addr;
        logic [7:0] data;
    } t_req;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] target_reg;
        logic [7:0] write_data;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_enable;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       read_last;
        logic       ack_error;
        logic       busy;
    } t_result;

endpackage

>>> rtl/i2crbm_cfg.sv
// ----------------------------------------------------------------------------
// i2crbm_cfg
// configuration register file, written through a valid/ready channel
// ----------------------------------------------------------------------------
module i2crbm_cfg
    import i2crbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_index,
    input  logic [7:0] i_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_valid) begin
            case (i_index)
                CFG_DEV_ADDR:    n_cfg.dev_addr    = i_data[6:0];
                CFG_BURST_REG:   n_cfg.burst_reg   = i_data;
                CFG_BURST_LEN:   n_cfg.burst_len   = i_data[4:0];
                CFG_PHASE_TICKS: n_cfg.phase_ticks = i_data;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr    <= DEV_ADDR_RST;
            r_cfg.burst_reg   <= BURST_REG_RST;
            r_cfg.burst_len   <= BURST_LEN_RST;
            r_cfg.phase_ticks <= PHASE_TICKS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> rtl/i2crbm_seq.sv
// ----------------------------------------------------------------------------
// i2crbm_seq
// bus phase sequencer: one tick of state update per step
// ----------------------------------------------------------------------------
module i2crbm_seq
    import i2crbm_pkg::*;
#(
    parameter int MAX_BURST = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    localparam int LW_RAW = $clog2(MAX_BURST + 1);
    localparam int LW     = (LW_RAW < 2) ? 2 : LW_RAW;

    t_phase        r_phase, n_phase, e_phase;
    logic [7:0]    r_tick,  n_tick,  e_tick;
    logic [2:0]    r_bit,   n_bit,   e_bit;
    logic [7:0]    r_shift, n_shift, e_shift;
    logic [LW-1:0] r_left,  n_left,  e_left;
    t_req          r_req,   n_req,   e_req;
    logic          r_nack,  n_nack;

    logic          start;
    logic          busy;
    logic          ending;
    logic          ackbit;
    logic [7:0]    plen;
    logic [2:0]    bit_inc;
    logic [7:0]    rx_shift;
    logic [4:0]    burst_n5;
    logic [LW-1:0] burst_n;
    logic          scl, sda, en;
    logic [7:0]    rbyte;
    logic          rvalid, rlast;

    // a start on an idle tick enters the first phase on that same tick
    assign start   = (r_phase == PH_IDLE) && (i_item.mode != MODE_TICK);
    assign e_phase = start ? PH_S_A : r_phase;
    assign e_tick  = start ? 8'd0 : r_tick;
    assign e_bit   = start ? 3'd0 : r_bit;
    assign e_shift = start ? {i_cfg.dev_addr, 1'b0} : r_shift;
    assign e_left  = start ? ((i_item.mode == MODE_WRITE) ? LW'(3) : LW'(2)) : r_left;
    assign e_req   = start ? {i_item.mode,
                              (i_item.mode == MODE_BURST) ? i_cfg.burst_reg
                                                          : i_item.target_reg,
                              i_item.write_data}
                           : r_req;

    assign busy     = (e_phase != PH_IDLE);
    assign ackbit   = (e_left <= LW'(1));
    assign plen     = (i_cfg.phase_ticks == 8'd0) ? 8'd1 : i_cfg.phase_ticks;
    assign ending   = busy && (({1'b0, e_tick} + 9'd1) >= {1'b0, plen});
    assign bit_inc  = e_bit + 3'd1;
    assign rx_shift = {e_shift[6:0], i_item.sda_in};

    // burst length, zero read as one, saturated to the burst limit
    assign burst_n5 = (i_cfg.burst_len == 5'd0) ? 5'd1 : i_cfg.burst_len;
    assign burst_n  = ({{LW{1'b0}}, burst_n5} > (LW + 5)'(MAX_BURST))
                      ? LW'(MAX_BURST) : LW'(burst_n5);

    // line levels of the current phase
    always_comb begin
        scl = 1'b1;
        sda = 1'b1;
        en  = 1'b0;
        case (e_phase)
            PH_S_A:   begin scl = 1'b1; sda = 1'b1;       en = 1'b1; end
            PH_S_B:   begin scl = 1'b1; sda = 1'b0;       en = 1'b1; end
            PH_S_C:   begin scl = 1'b0; sda = 1'b0;       en = 1'b1; end
            PH_TX_LO: begin scl = 1'b0; sda = e_shift[7]; en = 1'b1; end
            PH_TX_HI: begin scl = 1'b1; sda = e_shift[7]; en = 1'b1; end
            PH_TA_HI: scl = 1'b1;
            PH_TA_LO: scl = 1'b0;
            PH_RS:    begin scl = 1'b0; sda = 1'b1;       en = 1'b1; end
            PH_RX_LO: scl = 1'b0;
            PH_RX_HI: scl = 1'b1;
            PH_K_LO:  begin scl = 1'b0; sda = ackbit;     en = 1'b1; end
            PH_K_HI:  begin scl = 1'b1; sda = ackbit;     en = 1'b1; end
            PH_P_A:   begin scl = 1'b0; sda = 1'b0;       en = 1'b1; end
            PH_P_B:   begin scl = 1'b1; sda = 1'b0;       en = 1'b1; end
            PH_P_C:   begin scl = 1'b1; sda = 1'b1;       en = 1'b1; end
            default:  begin scl = 1'b1; sda = 1'b1;       en = 1'b0; end
        endcase
    end

    // next state
    always_comb begin
        n_phase = e_phase;
        n_tick  = e_tick;
        n_bit   = e_bit;
        n_shift = e_shift;
        n_left  = e_left;
        n_req   = e_req;
        n_nack  = r_nack;
        rbyte   = 8'd0;
        rvalid  = 1'b0;
        rlast   = 1'b0;
        if (busy && !ending) begin
            n_tick = e_tick + 8'd1;
        end
        if (ending) begin
            n_tick  = 8'd0;
            n_phase = PH_IDLE;
            case (e_phase)
                PH_S_A: n_phase = PH_S_B;
                PH_S_B: n_phase = PH_S_C;
                PH_S_C: begin
                    n_phase = PH_TX_LO;
                    n_bit   = 3'd0;
                end
                PH_TX_LO: n_phase = PH_TX_HI;
                PH_TX_HI: begin
                    n_shift = {e_shift[6:0], 1'b0};
                    n_bit   = bit_inc;
                    n_phase = (bit_inc == 3'd0) ? PH_TA_HI : PH_TX_LO;
                end
                PH_TA_HI: begin
                    n_nack  = i_item.sda_in;
                    n_phase = PH_TA_LO;
                end
                PH_TA_LO: begin
                    n_bit = 3'd0;
                    if (e_left == LW'(0)) begin
                        // read address sent, start receiving
                        n_left  = (e_req.kind == MODE_BURST) ? burst_n : LW'(1);
                        n_shift = 8'd0;
                        n_phase = PH_RX_LO;
                    end else if (e_left > LW'(1)) begin
                        n_left  = e_left - LW'(1);
                        n_shift = ((e_req.kind == MODE_WRITE) && (e_left == LW'(2)))
                                  ? e_req.data : e_req.reg_addr;
                        n_phase = PH_TX_LO;
                    end else if (e_req.kind == MODE_WRITE) begin
                        n_phase = PH_P_A;
                    end else begin
                        // repeated start with read bit
                        n_left  = LW'(0);
                        n_shift = {i_cfg.dev_addr, 1'b1};
                        n_phase = PH_RS;
                    end
                end
                PH_RS:    n_phase = PH_S_A;
                PH_RX_LO: n_phase = PH_RX_HI;
                PH_RX_HI: begin
                    n_shift = rx_shift;
                    n_bit   = bit_inc;
                    if (bit_inc == 3'd0) begin
                        rbyte   = rx_shift;
                        rvalid  = 1'b1;
                        rlast   = (e_left <= LW'(1));
                        n_phase = PH_K_LO;
                    end else begin
                        n_phase = PH_RX_LO;
                    end
                end
                PH_K_LO: n_phase = PH_K_HI;
                PH_K_HI: begin
                    if (e_left <= LW'(1)) begin
                        n_left  = LW'(0);
                        n_phase = PH_P_A;
                    end else begin
                        n_left  = e_left - LW'(1);
                        n_shift = 8'd0;
                        n_bit   = 3'd0;
                        n_phase = PH_RX_LO;
                    end
                end
                PH_P_A:  n_phase = PH_P_B;
                PH_P_B:  n_phase = PH_P_C;
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= 8'd0;
            r_bit   <= 3'd0;
            r_shift <= 8'd0;
            r_left  <= '0;
            r_req   <= '0;
            r_nack  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_left  <= n_left;
            r_req   <= n_req;
            r_nack  <= n_nack;
        end
    end

    assign o_res.scl        = scl;
    assign o_res.sda_out    = sda;
    assign o_res.sda_enable = en;
    assign o_res.read_byte  = rbyte;
    assign o_res.read_valid = rvalid;
    assign o_res.read_last  = rlast;
    assign o_res.ack_error  = n_nack;
    assign o_res.busy       = busy;

endmodule

>>> rtl/i2c_register_burst_master.sv
// ----------------------------------------------------------------------------
// i2c_register_burst_master
// tick-driven i2c master for register writes, reads and burst reads
// ----------------------------------------------------------------------------
// path: a tick accepted into the input register passes the sequencer step into the
// result register, whose result transaction is then offered; a sink stall can hold it
// throughput: one tick per clock cycle, set by the single-pass sequencer step
// between the input register and the result register; a sink stall holds both
// reset: synchronous active low; sequencer idle, bus released, config at defaults
// ----------------------------------------------------------------------------
module i2c_register_burst_master
    import i2crbm_pkg::*;
#(
    parameter int MAX_BURST = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // target_reg[7:0], write_data[15:8], sda_in[16]
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    // line and read result stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // scl[0], sda_out[1], sda_enable[2],
                                       // read_byte[10:3], ack_error[11], busy_res[12]
    output logic        m_axis_tuser,  // read_valid[0]
    output logic        m_axis_tlast,  // read_last
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    // input register
    logic    r_in_valid;
    t_item   r_in;
    // result register
    logic    r_out_valid;
    t_result r_out;

    t_cfg    cfg;
    t_result res;
    logic    advance;

    // the sequencer steps whenever a tick is held and the result slot frees up
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.mode        <= t_mode'(s_axis_tuser);
            r_in.target_reg  <= s_axis_tdata[7:0];
            r_in.write_data  <= s_axis_tdata[15:8];
            r_in.sda_in      <= s_axis_tdata[16];
        end
    end

    i2crbm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .o_ready (o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    i2crbm_seq #(
        .MAX_BURST (MAX_BURST)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // result register, held while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.busy, r_out.ack_error, r_out.read_byte,
                            r_out.sda_enable, r_out.sda_out, r_out.scl};
    assign m_axis_tuser  = r_out.read_valid;
    assign m_axis_tlast  = r_out.read_last;

`ifndef ASSERT_OFF
    // a received byte only shows up during a transaction
    a_read_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.read_valid |-> r_out.busy)
        else $error("read byte reported outside a transaction");

    // last marker only travels with a received byte
    a_last_with_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.read_last |-> r_out.read_valid)
        else $error("read_last without read_valid");

    // idle ticks leave the bus released with clock high
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.busy |-> r_out.scl && !r_out.sda_enable)
        else $error("bus driven while idle");

    // a held tick is not dropped while the result slot is blocked
    a_hold_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid)
        else $error("held tick lost");
`endif

endmodule

>>> tb/sv/tb_i2c_register_burst_master.sv
// ----------------------------------------------------------------------------
// tb_i2c_register_burst_master
// self-checking bench for the tick-driven i2c register burst master: a short
// stimulus table after reset, then one transaction with random content under
// each of a few register settings, each line result compared against a
// cycle-by-cycle model of the bus sequencer
// ----------------------------------------------------------------------------
module tb_i2c_register_burst_master
    import i2crbm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BURST_CAP = 16;
    localparam int CYCLE_LIMIT = 1000000;

    // line levels of an idle bus, and of the first tick of a start
    localparam t_result RES_IDLE = '{scl: 1'b1, sda_out: 1'b1, sda_enable: 1'b0,
                                     read_byte: 8'h00, read_valid: 1'b0,
                                     read_last: 1'b0, ack_error: 1'b0, busy: 1'b0};
    localparam t_result RES_START = '{scl: 1'b1, sda_out: 1'b1, sda_enable: 1'b1,
                                      read_byte: 8'h00, read_valid: 1'b0,
                                      read_last: 1'b0, ack_error: 1'b0, busy: 1'b1};

    // one row of the directed table
    typedef struct {
        t_item   item;
        logic    pinned;   // expected result typed in by hand
        t_result want;
        logic    run_out;  // keep ticking until the bus is idle again
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    // model of the sequencer: configuration and bus state
    t_cfg       cfg = '{dev_addr: DEV_ADDR_RST, burst_reg: BURST_REG_RST,
                        burst_len: BURST_LEN_RST, phase_ticks: PHASE_TICKS_RST};
    t_phase     bus_phase = PH_IDLE;
    logic [7:0] bus_ticks = '0;
    logic [2:0] bus_bit = '0;
    logic [7:0] bus_shift = '0;
    logic [4:0] bus_left = '0;
    t_req       bus_req = '{kind: MODE_TICK, reg_addr: 8'h00, data: 8'h00};
    logic       bus_nack = 1'b0;

    // line results still owed by the block, oldest first
    t_result bus_results_q[$];
    t_row    rows[$];

    // sender and receiver pacing
    logic        src_live = 1'b0;
    logic        gaps_on = 1'b1;
    int          burst_left = 0;
    int          stall_style = 1;
    logic [15:0] stall_pat = 16'b1101_1110_0111_0011;

    // bookkeeping
    int cycles = 0;
    int mismatches = 0;
    int ticks_sent = 0;
    int txns_started = 0;
    int bytes_read = 0;
    int cfg_writes = 0;

    i2c_register_burst_master #(
        .MAX_BURST(BURST_CAP)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // cycle limit, in case the block hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("i2c_register_burst_master: mismatch");
            $finish;
        end
    end

    // receiver back-pressure: always ready, random, or a rotating pattern
    always @(posedge i_clk) begin
        stall_pat <= {stall_pat[14:0], stall_pat[15]};
        case (stall_style)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 2) != 0);
            default: m_axis_tready <= stall_pat[0];
        endcase
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // output monitor: every result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (bus_results_q.size() == 0) begin
                $error("result transaction with nothing expected: tdata %0h", m_axis_tdata);
                mismatches++;
            end else begin
                exp_res = bus_results_q.pop_front();
                check_field("scl", exp_res.scl, m_axis_tdata[0]);
                check_field("sda_out", exp_res.sda_out, m_axis_tdata[1]);
                check_field("sda_enable", exp_res.sda_enable, m_axis_tdata[2]);
                check_field("read_byte", exp_res.read_byte, m_axis_tdata[10:3]);
                check_field("read_valid", exp_res.read_valid, m_axis_tuser);
                check_field("read_last", exp_res.read_last, m_axis_tlast);
                check_field("ack_error", exp_res.ack_error, m_axis_tdata[11]);
                check_field("busy_res", exp_res.busy, m_axis_tdata[12]);
                if (m_axis_tuser === 1'b1)
                    bytes_read++;
            end
        end
    end

    // one tick of the bus sequencer: line levels for this tick, then advance
    task automatic step_bus(input t_item it, output t_result res);
        int     plen;
        int     n;
        logic   ackbit;
        logic   ending;
        t_phase nxt;
        plen = (cfg.phase_ticks == 8'd0) ? 1 : int'(cfg.phase_ticks);
        ackbit = (bus_left <= 5'd1);
        res = RES_IDLE;

        // a start is only taken on an idle tick
        if (bus_phase == PH_IDLE && it.mode != MODE_TICK) begin
            bus_req.kind = it.mode;
            bus_req.reg_addr = (it.mode == MODE_BURST) ? cfg.burst_reg : it.target_reg;
            bus_req.data = it.write_data;
            bus_phase = PH_S_A;
            bus_ticks = '0;
            bus_bit = '0;
            bus_shift = {cfg.dev_addr, 1'b0};
            bus_left = (it.mode == MODE_WRITE) ? 5'd3 : 5'd2;
        end

        case (bus_phase)
            PH_S_A: begin res.scl = 1'b1; res.sda_out = 1'b1; res.sda_enable = 1'b1; end
            PH_S_B: begin res.scl = 1'b1; res.sda_out = 1'b0; res.sda_enable = 1'b1; end
            PH_S_C: begin res.scl = 1'b0; res.sda_out = 1'b0; res.sda_enable = 1'b1; end
            PH_TX_LO: begin
                res.scl = 1'b0; res.sda_out = bus_shift[7]; res.sda_enable = 1'b1;
            end
            PH_TX_HI: begin
                res.scl = 1'b1; res.sda_out = bus_shift[7]; res.sda_enable = 1'b1;
            end
            PH_TA_HI: res.scl = 1'b1;
            PH_TA_LO: res.scl = 1'b0;
            PH_RS: begin res.scl = 1'b0; res.sda_out = 1'b1; res.sda_enable = 1'b1; end
            PH_RX_LO: res.scl = 1'b0;
            PH_RX_HI: res.scl = 1'b1;
            PH_K_LO: begin res.scl = 1'b0; res.sda_out = ackbit; res.sda_enable = 1'b1; end
            PH_K_HI: begin res.scl = 1'b1; res.sda_out = ackbit; res.sda_enable = 1'b1; end
            PH_P_A: begin res.scl = 1'b0; res.sda_out = 1'b0; res.sda_enable = 1'b1; end
            PH_P_B: begin res.scl = 1'b1; res.sda_out = 1'b0; res.sda_enable = 1'b1; end
            PH_P_C: begin res.scl = 1'b1; res.sda_out = 1'b1; res.sda_enable = 1'b1; end
            default: bus_phase = PH_IDLE;
        endcase
        res.busy = (bus_phase != PH_IDLE);

        ending = res.busy && (int'(bus_ticks) + 1 >= plen);
        if (res.busy && !ending)
            bus_ticks = bus_ticks + 8'd1;

        if (ending) begin
            nxt = PH_IDLE;
            bus_ticks = '0;
            case (bus_phase)
                PH_S_A: nxt = PH_S_B;
                PH_S_B: nxt = PH_S_C;
                PH_S_C: begin nxt = PH_TX_LO; bus_bit = '0; end
                PH_TX_LO: nxt = PH_TX_HI;
                PH_TX_HI: begin
                    bus_shift = {bus_shift[6:0], 1'b0};
                    bus_bit = bus_bit + 3'd1;
                    nxt = (bus_bit == 3'd0) ? PH_TA_HI : PH_TX_LO;
                end
                PH_TA_HI: begin bus_nack = it.sda_in; nxt = PH_TA_LO; end
                PH_TA_LO: begin
                    bus_bit = '0;
                    if (bus_left == 5'd0) begin
                        // read address sent: switch to receiving
                        n = 1;
                        if (bus_req.kind == MODE_BURST) begin
                            n = (cfg.burst_len == 5'd0) ? 1 : int'(cfg.burst_len);
                            if (n > BURST_CAP)
                                n = BURST_CAP;
                        end
                        bus_left = n[4:0];
                        bus_shift = '0;
                        nxt = PH_RX_LO;
                    end else if (bus_left > 5'd1) begin
                        bus_left = bus_left - 5'd1;
                        if (bus_req.kind == MODE_WRITE && bus_left == 5'd1)
                            bus_shift = bus_req.data;
                        else
                            bus_shift = bus_req.reg_addr;
                        nxt = PH_TX_LO;
                    end else if (bus_req.kind == MODE_WRITE) begin
                        nxt = PH_P_A;
                    end else begin
                        // repeated start with the read address
                        bus_left = '0;
                        bus_shift = {cfg.dev_addr, 1'b1};
                        nxt = PH_RS;
                    end
                end
                PH_RS: nxt = PH_S_A;
                PH_RX_LO: nxt = PH_RX_HI;
                PH_RX_HI: begin
                    bus_shift = {bus_shift[6:0], it.sda_in};
                    bus_bit = bus_bit + 3'd1;
                    if (bus_bit == 3'd0) begin
                        res.read_byte = bus_shift;
                        res.read_valid = 1'b1;
                        res.read_last = (bus_left <= 5'd1);
                        nxt = PH_K_LO;
                    end else begin
                        nxt = PH_RX_LO;
                    end
                end
                PH_K_LO: nxt = PH_K_HI;
                PH_K_HI: begin
                    if (bus_left <= 5'd1) begin
                        bus_left = '0;
                        nxt = PH_P_A;
                    end else begin
                        bus_left = bus_left - 5'd1;
                        bus_shift = '0;
                        bus_bit = '0;
                        nxt = PH_RX_LO;
                    end
                end
                PH_P_A: nxt = PH_P_B;
                PH_P_B: nxt = PH_P_C;
                default: nxt = PH_IDLE;
            endcase
            bus_phase = nxt;
        end
        res.ack_error = bus_nack;
    endtask

    function automatic t_item rand_item(input t_mode m);
        t_item it;
        it.mode = m;
        it.target_reg = 8'($urandom_range(0, 255));
        it.write_data = 8'($urandom_range(0, 255));
        it.sda_in = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // drive one tick transaction, with a random gap between bursts
    task automatic send_item(input t_item it, input logic pinned, input t_result want);
        t_result pred;
        if (gaps_on && burst_left == 0) begin
            if (src_live) begin
                s_axis_tvalid <= 1'b0;
                src_live = 1'b0;
            end
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        if (burst_left > 0)
            burst_left--;
        if (bus_phase == PH_IDLE && it.mode != MODE_TICK)
            txns_started++;
        step_bus(it, pred);
        bus_results_q.push_back(pinned ? want : pred);
        s_axis_tvalid <= 1'b1;
        src_live = 1'b1;
        s_axis_tdata <= {7'd0, it.sda_in, it.write_data, it.target_reg};
        s_axis_tuser <= it.mode;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        ticks_sent++;
    endtask

    // hold the sender until every owed result has come out
    task automatic wait_drained();
        if (src_live) begin
            s_axis_tvalid <= 1'b0;
            src_live = 1'b0;
        end
        while (bus_results_q.size() != 0) @(posedge i_clk);
    endtask

    // tick on until the sequencer is idle; with noise, some ignored starts and an occasional drain
    task automatic finish_txn(input logic noise);
        t_mode m;
        while (bus_phase != PH_IDLE) begin
            m = MODE_TICK;
            if (noise && $urandom_range(0, 6) == 0)
                m = t_mode'($urandom_range(1, 3));
            send_item(rand_item(m), 1'b0, RES_IDLE);
            if (noise && $urandom_range(0, 149) == 0)
                wait_drained();
        end
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        case (idx)
            CFG_DEV_ADDR: cfg.dev_addr = val[6:0];
            CFG_BURST_REG: cfg.burst_reg = val;
            CFG_BURST_LEN: cfg.burst_len = val[4:0];
            CFG_PHASE_TICKS: cfg.phase_ticks = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    // registers only change with the pipeline empty and the bus idle
    task automatic set_config(input logic [7:0] dev, input logic [7:0] breg,
                              input logic [7:0] blen, input logic [7:0] pt);
        wait_drained();
        repeat (4) @(posedge i_clk);
        write_reg(CFG_DEV_ADDR, dev);
        write_reg(CFG_BURST_REG, breg);
        write_reg(CFG_BURST_LEN, blen);
        write_reg(CFG_PHASE_TICKS, pt);
        i_cfg_valid <= 1'b0;
    endtask

    // complete transactions of one kind with random content until the budget is spent
    task automatic run_random(input int budget, input t_mode m_fix);
        int start_count;
        start_count = ticks_sent;
        do begin
            // a few stray idle ticks now and then
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4)) send_item(rand_item(MODE_TICK), 1'b0, RES_IDLE);
            send_item(rand_item(m_fix), 1'b0, RES_IDLE);
            finish_txn(1'b1);
        end while (ticks_sent - start_count < budget);
    endtask

    task automatic add_row(input t_mode m, input logic [7:0] ra, input logic [7:0] wd,
                           input logic sda, input logic pinned, input t_result want,
                           input logic run_out);
        t_row r;
        r.item.mode = m;
        r.item.target_reg = ra;
        r.item.write_data = wd;
        r.item.sda_in = sda;
        r.pinned = pinned;
        r.want = want;
        r.run_out = run_out;
        rows.push_back(r);
    endtask

    initial begin
        logic [7:0] dev;
        logic [7:0] breg;
        logic [7:0] blen;
        logic [7:0] pt;
        t_mode      m_fix;

        // reset asserted once, at the start
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // short bus phases keep the directed part brief
        write_reg(CFG_PHASE_TICKS, 8'd1);
        i_cfg_valid <= 1'b0;

        // directed table at the reset address
        add_row(MODE_TICK, 8'h00, 8'h00, 1'b0, 1'b1, RES_IDLE, 1'b0);
        add_row(MODE_TICK, 8'hFF, 8'hFF, 1'b1, 1'b1, RES_IDLE, 1'b0);   // idle tick ignored
        add_row(MODE_READ, 8'h00, 8'hFF, 1'b0, 1'b1, RES_START, 1'b0);
        add_row(MODE_BURST, 8'hFF, 8'h00, 1'b1, 1'b0, RES_IDLE, 1'b0);  // start while busy
        add_row(MODE_WRITE, 8'hAA, 8'h55, 1'b0, 1'b0, RES_IDLE, 1'b1);  // start while busy
        foreach (rows[i]) begin
            send_item(rows[i].item, rows[i].pinned, rows[i].want);
            if (rows[i].run_out)
                finish_txn(1'b0);
        end

        // random part over a few register settings
        for (int p = 0; p < 3; p++) begin
            dev = 8'($urandom_range(0, 255));
            breg = 8'($urandom_range(0, 255));
            blen = 8'($urandom_range(1, 3));
            pt = 8'd2;
            m_fix = MODE_WRITE;
            case (p)
                0: begin
                    // zero burst length and zero phase both fall back to one
                    dev = 8'h00; breg = 8'h00; blen = 8'd0; pt = 8'd0;
                    m_fix = MODE_BURST;
                end
                1: begin
                    // top address bit dropped, burst saturates
                    dev = 8'hFF; breg = 8'hFF; blen = 8'd31; pt = 8'd1;
                    m_fix = MODE_BURST;
                end
                default: ;
            endcase
            set_config(dev, breg, blen, pt);
            stall_style = p;
            gaps_on = (p != 1);
            burst_left = 0;
            run_random(1, m_fix);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("covered %0d ticks, %0d transactions started, %0d bytes read back",
                 ticks_sent, txns_started, bytes_read);
        $display("%0d register writes: short phases, zero fallbacks, a saturated burst",
                 cfg_writes);
        if (mismatches == 0 && bus_results_q.size() == 0) begin
            $display("i2c_register_burst_master: match");
        end else begin
            $display("i2c_register_burst_master: mismatch");
        end
        $finish;
    end

endmodule

>>> i2c_register_burst_master.f
rtl/i2crbm_pkg.sv
rtl/i2crbm_cfg.sv
rtl/i2crbm_seq.sv
rtl/i2c_register_burst_master.sv
tb/sv/tb_i2c_register_burst_master.sv
